// File: design/teb_pkg.sv
// ----------------------------------------------------------------------------
// teb_pkg - timestamp event builder shared definitions
// Codes, field widths and the result word type used by every block file.
// ----------------------------------------------------------------------------
package teb_pkg;

    // Field widths fixed by the interface
    localparam int LOCAL_BITS   = 40;
    localparam int ID_BITS      = 16;
    localparam int TIME_OUT_W   = 52;
    localparam int DIST_OUT_W   = 53;
    localparam int STAT_OUT_W   = 48;
    localparam int COUNT_W      = 8;

    // Parameter defaults
    localparam int GROUP_BITS_DEF   = 12;
    localparam int COUNTER_BITS_DEF = 48;

    // Multiplicity bins: 1, 2, 3, 4 or more
    localparam int NBINS = 4;

    // Result queue depth (room for two results per input word)
    localparam int Q_DEPTH = 4;

    // Saturation value of the per-event hit count
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    // Input function codes
    localparam logic [1:0] FUNC_HIT   = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_STAT  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_CLOSED  = 2'd0;
    localparam logic [1:0] KIND_STORED  = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;
    localparam logic [1:0] KIND_STAT    = 2'd3;

    // Statistic selectors
    localparam logic [2:0] SEL_BIN_LAST = 3'd3;
    localparam logic [2:0] SEL_EVENTS   = 3'd4;
    localparam logic [2:0] SEL_HITS     = 3'd5;
    localparam logic [2:0] SEL_DECS     = 3'd6;

    // One result word
    typedef struct packed {
        logic [1:0]                   kind;
        logic [TIME_OUT_W-1:0]        event_time;
        logic signed [DIST_OUT_W-1:0] time_since_last;
        logic [COUNT_W-1:0]           hit_count;
        logic [COUNT_W-1:0]           hit_slot;
        logic [ID_BITS-1:0]           out_module;
        logic [ID_BITS-1:0]           out_channel;
        logic [ID_BITS-1:0]           out_energy;
        logic [STAT_OUT_W-1:0]        stat_value;
        logic                         last;
    } result_t;

    // Queue write strobes for the results of one input word
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

// File: design/teb_front.sv
// ----------------------------------------------------------------------------
// teb_front - input register
// Captures one input word, extending the timestamp by its rollover group,
// and releases it to the builder core when the result queue has room.
// ----------------------------------------------------------------------------
module teb_front #(
    parameter int GROUP_BITS = teb_pkg::GROUP_BITS_DEF,
    localparam int TW = teb_pkg::LOCAL_BITS + GROUP_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [teb_pkg::ID_BITS-1:0]    module_id,
    input  logic [teb_pkg::ID_BITS-1:0]    channel_id,
    input  logic [teb_pkg::ID_BITS-1:0]    energy,
    input  logic [teb_pkg::LOCAL_BITS-1:0] local_time,
    input  logic [GROUP_BITS-1:0]          rollover_group,
    input  logic [2:0]                     stat_select,
    input  logic                           room,
    output logic                           go,
    output logic [1:0]                     func_q,
    output logic [teb_pkg::ID_BITS-1:0]    module_q,
    output logic [teb_pkg::ID_BITS-1:0]    channel_q,
    output logic [teb_pkg::ID_BITS-1:0]    energy_q,
    output logic [TW-1:0]                  time_q,
    output logic [2:0]                     sel_q
);

    logic                          valid_reg;
    logic                          valid_next;
    logic                          accept;
    logic [TW-1:0]                 ext_time;
    logic [1:0]                    func_reg;
    logic [teb_pkg::ID_BITS-1:0]   module_reg;
    logic [teb_pkg::ID_BITS-1:0]   channel_reg;
    logic [teb_pkg::ID_BITS-1:0]   energy_reg;
    logic [TW-1:0]                 time_reg;
    logic [2:0]                    sel_reg;

    // Extend: local + group * (2^40 - 1) = local + (group << 40) - group
    assign ext_time = {rollover_group, {teb_pkg::LOCAL_BITS{1'b0}}}
                    - TW'(rollover_group) + TW'(local_time);

    // Release the held word when the queue can take two results
    assign go       = valid_reg & room;
    assign in_stall = valid_reg & ~room;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (go)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload of the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            module_reg  <= module_id;
            channel_reg <= channel_id;
            energy_reg  <= energy;
            time_reg    <= ext_time;
            sel_reg     <= stat_select;
        end
    end

    assign func_q    = func_reg;
    assign module_q  = module_reg;
    assign channel_q = channel_reg;
    assign energy_q  = energy_reg;
    assign time_q    = time_reg;
    assign sel_q     = sel_reg;

endmodule

// File: design/teb_core.sv
// ----------------------------------------------------------------------------
// teb_core - event grouping and statistics
// Compares each hit with the open event time, closes and opens events,
// keeps the statistic counters and forms up to two result words.
// ----------------------------------------------------------------------------
module teb_core #(
    parameter int GROUP_BITS   = teb_pkg::GROUP_BITS_DEF,
    parameter int COUNTER_BITS = teb_pkg::COUNTER_BITS_DEF,
    localparam int TW = teb_pkg::LOCAL_BITS + GROUP_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [1:0]                  func_q,
    input  logic [teb_pkg::ID_BITS-1:0] module_q,
    input  logic [teb_pkg::ID_BITS-1:0] channel_q,
    input  logic [teb_pkg::ID_BITS-1:0] energy_q,
    input  logic [TW-1:0]               time_q,
    input  logic [2:0]                  sel_q,
    output teb_pkg::push_t              push,
    output teb_pkg::result_t            res0,
    output teb_pkg::result_t            res1
);

    localparam int CW = COUNTER_BITS;
    localparam int BW = $clog2(teb_pkg::NBINS);

    // Event state
    logic                         have_prev_reg,  have_prev_next;
    logic [TW-1:0]                cur_time_reg,   cur_time_next;
    logic [TW-1:0]                low_mark_reg,   low_mark_next;
    logic                         open_reg,       open_next;
    logic [teb_pkg::COUNT_W-1:0]  open_cnt_reg,   open_cnt_next;
    logic                         last_valid_reg, last_valid_next;
    logic [TW-1:0]                last_time_reg,  last_time_next;

    // Statistics
    logic [CW-1:0] mult_reg  [teb_pkg::NBINS];
    logic [CW-1:0] mult_next [teb_pkg::NBINS];
    logic [CW-1:0] events_reg, events_next;
    logic [CW-1:0] hits_reg,   hits_next;
    logic [CW-1:0] decs_reg,   decs_next;

    logic                               do_close;
    logic                               do_open;
    logic [BW-1:0]                      bin;
    logic [TW-1:0]                      evt_gap;
    logic [TW+teb_pkg::DIST_OUT_W-1:0]  dist_wide;
    logic [TW+teb_pkg::TIME_OUT_W-1:0]  cur_wide;
    logic [TW+teb_pkg::TIME_OUT_W-1:0]  hit_wide;
    logic [CW+teb_pkg::STAT_OUT_W-1:0]  stat_wide;
    logic [CW-1:0]                      stat_cnt;
    teb_pkg::result_t                   close_res;
    teb_pkg::result_t                   hit_res;
    teb_pkg::result_t                   stat_res;

    // Bin the open event's multiplicity: 1, 2, 3, 4 or more
    always_comb
    begin
        if (open_cnt_reg >= teb_pkg::COUNT_W'(teb_pkg::NBINS))
        begin
            bin = BW'(teb_pkg::NBINS - 1);
        end
        else if (open_cnt_reg == '0)
        begin
            bin = '0;
        end
        else
        begin
            bin = BW'(open_cnt_reg - teb_pkg::COUNT_W'(1));
        end
    end

    // Closed event word
    assign evt_gap   = cur_time_reg - last_time_reg;
    assign dist_wide = {{teb_pkg::DIST_OUT_W{1'b0}}, evt_gap};
    assign cur_wide  = {{teb_pkg::TIME_OUT_W{1'b0}}, cur_time_reg};

    always_comb
    begin
        close_res            = '0;
        close_res.kind       = teb_pkg::KIND_CLOSED;
        close_res.event_time = cur_wide[teb_pkg::TIME_OUT_W-1:0];
        close_res.hit_count  = open_cnt_reg;
        if (last_valid_reg)
        begin
            close_res.time_since_last = signed'(dist_wide[teb_pkg::DIST_OUT_W-1:0]);
        end
        else
        begin
            close_res.time_since_last = '1;
        end
    end

    // Hit word, slot and kind set per branch below
    assign hit_wide = {{teb_pkg::TIME_OUT_W{1'b0}}, time_q};

    always_comb
    begin
        hit_res             = '0;
        hit_res.kind        = teb_pkg::KIND_STORED;
        hit_res.event_time  = hit_wide[teb_pkg::TIME_OUT_W-1:0];
        hit_res.out_module  = module_q;
        hit_res.out_channel = channel_q;
        hit_res.out_energy  = energy_q;
    end

    // Statistic read-back
    always_comb
    begin
        case (sel_q) inside
            [3'd0:teb_pkg::SEL_BIN_LAST]: stat_cnt = mult_reg[sel_q[BW-1:0]];
            teb_pkg::SEL_EVENTS:          stat_cnt = events_reg;
            teb_pkg::SEL_HITS:            stat_cnt = hits_reg;
            teb_pkg::SEL_DECS:            stat_cnt = decs_reg;
            default:                      stat_cnt = '0;
        endcase
    end

    assign stat_wide = {{teb_pkg::STAT_OUT_W{1'b0}}, stat_cnt};

    always_comb
    begin
        stat_res            = '0;
        stat_res.kind       = teb_pkg::KIND_STAT;
        stat_res.stat_value = stat_wide[teb_pkg::STAT_OUT_W-1:0];
    end

    // Decide the action for the released word
    always_comb
    begin
        have_prev_next  = have_prev_reg;
        cur_time_next   = cur_time_reg;
        low_mark_next   = low_mark_reg;
        open_next       = open_reg;
        open_cnt_next   = open_cnt_reg;
        last_valid_next = last_valid_reg;
        last_time_next  = last_time_reg;
        events_next     = events_reg;
        hits_next       = hits_reg;
        decs_next       = decs_reg;
        do_close        = 1'b0;
        do_open         = 1'b0;
        push            = '0;
        res0            = '0;
        res1            = '0;

        if (go)
        begin
            case (func_q)
                teb_pkg::FUNC_HIT:
                begin
                    if (!have_prev_reg || time_q > cur_time_reg)
                    begin
                        // Later hit: close any open event, open a new one
                        do_open = 1'b1;
                        if (open_reg)
                        begin
                            do_close    = 1'b1;
                            res0        = close_res;
                            res1        = hit_res;
                            push.first  = 1'b1;
                            push.second = 1'b1;
                        end
                        else
                        begin
                            res0       = hit_res;
                            push.first = 1'b1;
                        end
                    end
                    else if (time_q == cur_time_reg)
                    begin
                        res0       = hit_res;
                        push.first = 1'b1;
                        if (open_reg)
                        begin
                            // Join the open event
                            res0.hit_slot = open_cnt_reg;
                            hits_next     = hits_reg + CW'(1);
                            if (open_cnt_reg != teb_pkg::COUNT_SAT)
                            begin
                                open_cnt_next = open_cnt_reg + teb_pkg::COUNT_W'(1);
                            end
                        end
                        else
                        begin
                            // Same time after a flush opens a fresh event
                            do_open = 1'b1;
                        end
                    end
                    else
                    begin
                        // Earlier hit: drop, count a new low mark
                        if (time_q < low_mark_reg)
                        begin
                            low_mark_next = time_q;
                            decs_next     = decs_reg + CW'(1);
                        end
                        res0       = hit_res;
                        res0.kind  = teb_pkg::KIND_DROPPED;
                        push.first = 1'b1;
                    end
                end
                teb_pkg::FUNC_FLUSH:
                begin
                    if (open_reg)
                    begin
                        do_close   = 1'b1;
                        res0       = close_res;
                        push.first = 1'b1;
                    end
                end
                teb_pkg::FUNC_STAT:
                begin
                    res0       = stat_res;
                    push.first = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (do_close)
            begin
                last_valid_next = 1'b1;
                last_time_next  = cur_time_reg;
                open_next       = 1'b0;
                open_cnt_next   = '0;
            end

            if (do_open)
            begin
                cur_time_next  = time_q;
                low_mark_next  = time_q;
                have_prev_next = 1'b1;
                open_next      = 1'b1;
                open_cnt_next  = teb_pkg::COUNT_W'(1);
                events_next    = events_reg + CW'(1);
                hits_next      = hits_reg + CW'(1);
            end

            // Mark the final word of this input
            res0.last = push.first & ~push.second;
            res1.last = push.second;
        end
    end

    // Advance the bin counter of a closing event
    always_comb
    begin
        for (int i = 0; i < teb_pkg::NBINS; i++)
        begin
            if (do_close && bin == BW'(i))
            begin
                mult_next[i] = mult_reg[i] + CW'(1);
            end
            else
            begin
                mult_next[i] = mult_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg  <= 1'b0;
            cur_time_reg   <= '0;
            low_mark_reg   <= '0;
            open_reg       <= 1'b0;
            open_cnt_reg   <= '0;
            last_valid_reg <= 1'b0;
            last_time_reg  <= '0;
            events_reg     <= '0;
            hits_reg       <= '0;
            decs_reg       <= '0;
            for (int i = 0; i < teb_pkg::NBINS; i++)
            begin
                mult_reg[i] <= '0;
            end
        end
        else
        begin
            have_prev_reg  <= have_prev_next;
            cur_time_reg   <= cur_time_next;
            low_mark_reg   <= low_mark_next;
            open_reg       <= open_next;
            open_cnt_reg   <= open_cnt_next;
            last_valid_reg <= last_valid_next;
            last_time_reg  <= last_time_next;
            events_reg     <= events_next;
            hits_reg       <= hits_next;
            decs_reg       <= decs_next;
            for (int i = 0; i < teb_pkg::NBINS; i++)
            begin
                mult_reg[i] <= mult_next[i];
            end
        end
    end

endmodule

// File: design/teb_queue.sv
// ----------------------------------------------------------------------------
// teb_queue - result queue
// Small register queue taking up to two result words per cycle and
// presenting one word per cycle on the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module teb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  teb_pkg::push_t   push,
    input  teb_pkg::result_t res0,
    input  teb_pkg::result_t res1,
    output logic             room,
    output logic             out_valid,
    input  logic             out_stall,
    output teb_pkg::result_t head
);

    localparam int PW = $clog2(teb_pkg::Q_DEPTH);
    localparam int NW = PW + 1;

    teb_pkg::result_t q_reg [teb_pkg::Q_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg,  count_next;
    logic             pop;

    // Room for a full pair of results, judged on the registered fill only
    assign room      = count_reg <= NW'(teb_pkg::Q_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign pop       = out_valid & ~out_stall;
    assign head      = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.first) + PW'(push.second);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + NW'(push.first) + NW'(push.second) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the words of the current input in order
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (push.second)
        begin
            q_reg[wr_ptr_reg + PW'(1)] <= res1;
        end
    end

endmodule

// File: design/timestamp_event_builder.sv
// ----------------------------------------------------------------------------
// timestamp_event_builder - timestamp coincidence event builder
// Groups digitizer hits with equal extended timestamps into events and
// keeps multiplicity, event, hit and decrease counters for read-back.
// ----------------------------------------------------------------------------
// The block takes one input word per clock while the input is not stalled. Each
// word is registered in teb_front, decided by teb_core once the queue has room,
// and its results (none, one or two words) enter a four-entry result queue. The
// output port delivers one word per clock while out_stall is low, so a steady
// stream of hits that each close an event (two results apiece) fills the queue
// and stalls the input; all other words run at one per clock while out_stall is low.
// The input stalls only while the queue could not take two more words.
module timestamp_event_builder #(
    parameter int GROUP_BITS   = teb_pkg::GROUP_BITS_DEF,
    parameter int COUNTER_BITS = teb_pkg::COUNTER_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              func,
    input  logic [teb_pkg::ID_BITS-1:0]             module_id,
    input  logic [teb_pkg::ID_BITS-1:0]             channel_id,
    input  logic [teb_pkg::ID_BITS-1:0]             energy,
    input  logic [teb_pkg::LOCAL_BITS-1:0]          local_time,
    input  logic [GROUP_BITS-1:0]                   rollover_group,
    input  logic [2:0]                              stat_select,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [1:0]                              kind,
    output logic [teb_pkg::TIME_OUT_W-1:0]          event_time,
    output logic signed [teb_pkg::DIST_OUT_W-1:0]   time_since_last,
    output logic [teb_pkg::COUNT_W-1:0]             hit_count,
    output logic [teb_pkg::COUNT_W-1:0]             hit_slot,
    output logic [teb_pkg::ID_BITS-1:0]             out_module,
    output logic [teb_pkg::ID_BITS-1:0]             out_channel,
    output logic [teb_pkg::ID_BITS-1:0]             out_energy,
    output logic [teb_pkg::STAT_OUT_W-1:0]          stat_value,
    output logic                                    last
);

    localparam int TW = teb_pkg::LOCAL_BITS + GROUP_BITS;

    logic                        room;
    logic                        go;
    logic [1:0]                  func_q;
    logic [teb_pkg::ID_BITS-1:0] module_q;
    logic [teb_pkg::ID_BITS-1:0] channel_q;
    logic [teb_pkg::ID_BITS-1:0] energy_q;
    logic [TW-1:0]               time_q;
    logic [2:0]                  sel_q;
    teb_pkg::push_t              push;
    teb_pkg::result_t            res0;
    teb_pkg::result_t            res1;
    teb_pkg::result_t            head;

    // Input register with timestamp extension
    teb_front #(
        .GROUP_BITS (GROUP_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .module_id      (module_id),
        .channel_id     (channel_id),
        .energy         (energy),
        .local_time     (local_time),
        .rollover_group (rollover_group),
        .stat_select    (stat_select),
        .room           (room),
        .go             (go),
        .func_q         (func_q),
        .module_q       (module_q),
        .channel_q      (channel_q),
        .energy_q       (energy_q),
        .time_q         (time_q),
        .sel_q          (sel_q)
    );

    // Event grouping and counters
    teb_core #(
        .GROUP_BITS   (GROUP_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .func_q    (func_q),
        .module_q  (module_q),
        .channel_q (channel_q),
        .energy_q  (energy_q),
        .time_q    (time_q),
        .sel_q     (sel_q),
        .push      (push),
        .res0      (res0),
        .res1      (res1)
    );

    // Result queue
    teb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res0      (res0),
        .res1      (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind            = head.kind;
    assign event_time      = head.event_time;
    assign time_since_last = head.time_since_last;
    assign hit_count       = head.hit_count;
    assign hit_slot        = head.hit_slot;
    assign out_module      = head.out_module;
    assign out_channel     = head.out_channel;
    assign out_energy      = head.out_energy;
    assign stat_value      = head.stat_value;
    assign last            = head.last;

endmodule

// File: design/teb_checker.sv
// ----------------------------------------------------------------------------
// teb_checker - output port checks
// Watches the result channel of the event builder and flags words that
// break the rules of result kinds; attached to the top level by bind.
// ----------------------------------------------------------------------------
module teb_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [1:0]                            kind,
    input logic [teb_pkg::TIME_OUT_W-1:0]        event_time,
    input logic signed [teb_pkg::DIST_OUT_W-1:0] time_since_last,
    input logic [teb_pkg::COUNT_W-1:0]           hit_count,
    input logic                                  last
);

    // A stalled word stays on the port with its kind, event time and last flag unchanged
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind)
            && $stable(event_time) && $stable(last))
        else $error("result word changed while stalled");

    // A closed event holds at least one hit
    a_closed_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == teb_pkg::KIND_CLOSED |-> hit_count != '0)
        else $error("closed event with no hits");

    // Statistics and dropped hits are always the only word of their input
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == teb_pkg::KIND_STAT || kind == teb_pkg::KIND_DROPPED)
            |-> last)
        else $error("single-result word not marked last");

    // Distance is reported on closed events only
    a_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != teb_pkg::KIND_CLOSED |-> time_since_last == '0)
        else $error("distance on a word that is not a closed event");

endmodule

bind timestamp_event_builder teb_checker u_teb_checker (.*);
